/* rtl/core/flash_ring_log_command_generator_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the flash ring log command generator
// Define NO_ASSERTIONS to compile every check away.
// ----------------------------------------------------------------------------
`ifndef FLASH_RING_LOG_COMMAND_GENERATOR_TOP_ASSERT_SVH
`define FLASH_RING_LOG_COMMAND_GENERATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is high
`define FRLCG_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset
`define FRLCG_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRLCG_ASSERT(name, clk, rst, prop, msg)
`define FRLCG_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

/* rtl/core/frlcg_pkg.sv */
// ----------------------------------------------------------------------------
// frlcg_pkg
// Shared types, constants and command codes of the log command generator.
// ----------------------------------------------------------------------------
package frlcg_pkg;

  localparam int ADDR_W           = 24;
  localparam int ADDR_BITS        = 24;
  localparam int PAGE_BITS        = 8;
  localparam int SECTOR_BITS      = 12;
  localparam int PAGE_BYTES       = 1 << PAGE_BITS;
  localparam int MAX_SAMPLE_BYTES = 1024;
  localparam int MAX_RESULTS      = 6;
  localparam int LEN_W            = 11;
  localparam int CNT_W            = 9;
  localparam int OFFS_W           = 10;
  localparam int SAMPLES_W        = 32;
  localparam int CFG_IDX_W        = 2;
  localparam int N_W              = $clog2(MAX_RESULTS + 1);
  localparam int SUM_W            = ADDR_W + 1;

  localparam logic [SUM_W-1:0] SUM_MASK =
    (ADDR_BITS >= SUM_W) ? {SUM_W{1'b1}} : SUM_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] SECTOR_MASK = ADDR_W'((1 << SECTOR_BITS) - 1);
  localparam logic [LEN_W-1:0]  MAX_LEN     = LEN_W'(MAX_SAMPLE_BYTES);

  localparam logic [ADDR_W-1:0] TEST_START_RESET = 24'd2097152;
  localparam logic [ADDR_W-1:0] TEST_END_RESET   = 24'd4186112;

  localparam logic [CFG_IDX_W-1:0] CFG_TEST_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_END   = 2'd1;

  localparam logic CMD_ERASE   = 1'b0;
  localparam logic CMD_PROGRAM = 1'b1;

  typedef struct packed {
    logic             func;
    logic [LEN_W-1:0] sample_bytes;
  } req_t;

  typedef struct packed {
    logic                 command_kind;
    logic [ADDR_W-1:0]    flash_address;
    logic [CNT_W-1:0]     byte_count;
    logic [OFFS_W-1:0]    sample_offset;
    logic                 last_command;
    logic [SAMPLES_W-1:0] samples_written;
  } cmd_t;

  typedef struct packed {
    logic load;
    logic emit_erase;
    logic emit_prog;
  } ctrl_t;

  typedef struct packed {
    logic sample_empty;
    logic start_aligned;
    logic last_chunk;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/frlcg_ctrl.sv */
// ----------------------------------------------------------------------------
// frlcg_ctrl
// Sequencer: accept a request, issue an optional erase, then page chunks.
// ----------------------------------------------------------------------------
module frlcg_ctrl import frlcg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ERASE = 2'd1;
  localparam logic [1:0] ST_PROG  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && !stat.sample_empty) begin
          ctrl.load  = 1'b1;
          state_next = stat.start_aligned ? ST_ERASE : ST_PROG;
        end
      end
      ST_ERASE: begin
        if (stat.out_free) begin
          ctrl.emit_erase = 1'b1;
          state_next      = ST_PROG;
        end
      end
      ST_PROG: begin
        if (stat.out_free) begin
          ctrl.emit_prog = 1'b1;
          if (stat.last_chunk) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/frlcg_datapath.sv */
// ----------------------------------------------------------------------------
// frlcg_datapath
// Region state, working registers, chunk arithmetic and output register.
// ----------------------------------------------------------------------------
module frlcg_datapath import frlcg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  ctrl_t                ctrl,
  output stat_t                stat,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd_data
);

  logic [ADDR_W-1:0]    test_start;
  logic [ADDR_W-1:0]    test_end;
  logic [ADDR_W-1:0]    normal_addr;
  logic [SAMPLES_W-1:0] normal_count;
  logic [ADDR_W-1:0]    test_addr;
  logic [SAMPLES_W-1:0] test_count;

  logic                 wfunc;
  logic [ADDR_W-1:0]    waddr;
  logic [LEN_W-1:0]     wrem;
  logic [LEN_W-1:0]     woffs;
  logic [SAMPLES_W-1:0] wcount;
  logic [ADDR_W-1:0]    wstart;
  logic [ADDR_W-1:0]    wend;
  logic [N_W-1:0]       wn;

  logic [ADDR_W-1:0]    sel_addr;
  logic [SAMPLES_W-1:0] sel_count;
  logic [ADDR_W-1:0]    start_al;
  logic [ADDR_W-1:0]    end_al;
  logic [LEN_W-1:0]     req_len;
  logic [CNT_W-1:0]     room;
  logic [CNT_W-1:0]     chunk;
  logic [LEN_W-1:0]     rem_after;
  logic [SUM_W-1:0]     sum;
  logic [ADDR_W-1:0]    addr_next;
  logic                 last;

  assign start_al  = test_start & ~SECTOR_MASK;
  assign end_al    = test_end & ~SECTOR_MASK;
  assign sel_addr  = req_data.func ? test_addr : normal_addr;
  assign sel_count = req_data.func ? test_count : normal_count;
  assign req_len   = (req_data.sample_bytes > MAX_LEN) ? MAX_LEN : req_data.sample_bytes;

  // Chunk stops at the page boundary or at the end of the sample.
  assign room      = CNT_W'(PAGE_BYTES) - CNT_W'(waddr[PAGE_BITS-1:0]);
  assign chunk     = (LEN_W'(room) > wrem) ? wrem[CNT_W-1:0] : room;
  assign rem_after = wrem - LEN_W'(chunk);
  assign last      = (rem_after == '0) || (wn == N_W'(MAX_RESULTS - 1));

  // Advance, wrap modulo the address space, then back to the region start.
  assign sum       = ({1'b0, waddr} + SUM_W'(chunk)) & SUM_MASK;
  assign addr_next = (sum >= {1'b0, wend}) ? wstart : sum[ADDR_W-1:0];

  assign stat.sample_empty  = (req_data.sample_bytes == '0);
  assign stat.start_aligned = ((sel_addr & SECTOR_MASK) == '0);
  assign stat.last_chunk    = last;
  assign stat.out_free      = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_start   <= TEST_START_RESET;
      test_end     <= TEST_END_RESET;
      normal_addr  <= '0;
      normal_count <= '0;
      test_addr    <= TEST_START_RESET;
      test_count   <= '0;
    end else begin
      if (cfg_valid && cfg_index == CFG_TEST_START) begin
        test_start <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_TEST_END) begin
        test_end <= cfg_data;
      end
      if (ctrl.emit_prog && last) begin
        if (wfunc) begin
          test_addr  <= addr_next;
          test_count <= wcount;
        end else begin
          normal_addr  <= addr_next;
          normal_count <= wcount;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      wfunc  <= req_data.func;
      waddr  <= sel_addr;
      wrem   <= req_len;
      woffs  <= '0;
      wcount <= sel_count + SAMPLES_W'(1);
      wstart <= req_data.func ? start_al : '0;
      wend   <= req_data.func ? end_al : start_al;
      wn     <= '0;
    end else if (ctrl.emit_erase) begin
      wn <= wn + N_W'(1);
    end else if (ctrl.emit_prog) begin
      waddr <= addr_next;
      wrem  <= rem_after;
      woffs <= woffs + LEN_W'(chunk);
      wn    <= wn + N_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_erase) begin
      cmd_data.command_kind    <= CMD_ERASE;
      cmd_data.flash_address   <= waddr;
      cmd_data.byte_count      <= '0;
      cmd_data.sample_offset   <= '0;
      cmd_data.last_command    <= 1'b0;
      cmd_data.samples_written <= '0;
    end else if (ctrl.emit_prog) begin
      cmd_data.command_kind    <= CMD_PROGRAM;
      cmd_data.flash_address   <= waddr;
      cmd_data.byte_count      <= chunk;
      cmd_data.sample_offset   <= woffs[OFFS_W-1:0];
      cmd_data.last_command    <= last;
      cmd_data.samples_written <= last ? wcount : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (ctrl.emit_erase || ctrl.emit_prog) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/flash_ring_log_command_generator_top.sv */
// ----------------------------------------------------------------------------
// flash_ring_log_command_generator_top: circular flash log command generator
// A sample (optional erase plus page chunks) is accepted, then its commands go one
// at a time into the output register, paced by its drain.
// Synchronous reset restores register defaults, write addresses and counts.
// ----------------------------------------------------------------------------
`include "flash_ring_log_command_generator_top_assert.svh"

module flash_ring_log_command_generator_top import frlcg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // request channel: one non-empty transfer appends one sample
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req_data,
  // command channel: one transfer per flash command
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd_data,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  ctrl_t ctrl;
  stat_t stat;

  // The user must write registers only while idle; the block does not enforce this and takes them every cycle.
  assign cfg_ready = 1'b1;

  // Sequencer: holds the request channel closed while a sample is in flight.
  // The final command moves it back to idle as soon as it is loaded into the
  // output register, so the next request overlaps that command's drain.
  frlcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Datapath: region pointers and counts, chunk split, wrap, output register.
  frlcg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data)
  );

  // A non-empty request transfer always makes the block busy.
  `FRLCG_ASSERT(a_busy_after_req, clk, rst, (req_valid && req_ready && req_data.sample_bytes != '0) |=> !req_ready, "request accepted but block stayed idle")

  // While a non-final command waits, the sample is still in progress.
  `FRLCG_ASSERT(a_mid_sample_busy, clk, rst, (cmd_valid && !cmd_data.last_command) |-> !req_ready, "idle with a non-final command pending")

  // Erase commands target a sector boundary and carry no bytes.
  `FRLCG_ASSERT(a_erase_shape, clk, rst, (cmd_valid && cmd_data.command_kind == CMD_ERASE) |-> ((cmd_data.flash_address & SECTOR_MASK) == '0 && cmd_data.byte_count == '0 && !cmd_data.last_command), "malformed erase command")

  // The sample count travels only on the final command.
  `FRLCG_ASSERT(a_count_on_last, clk, rst, (cmd_valid && !cmd_data.last_command) |-> (cmd_data.samples_written == '0), "sample count on a non-final command")

endmodule
